[sv/fmpc_pkg.sv]
// Shared types and constants for the flow meter pulse counter.
package fmpc_pkg;

  localparam int unsigned DefaultPorts = 4;
  localparam int unsigned MaxPorts     = 16;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned PortW   = 4;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned HistW   = 8;

  localparam logic [HistW-1:0]  HistMask     = 8'hFF;
  localparam logic [HistW-1:0]  PulsePattern = 8'hF0;
  localparam logic [TimerW-1:0] TimerMax     = 16'hFFFF;
  localparam logic [TimerW-1:0] ResetTimeout = 16'd1000;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE      = 3'd0,
    MODE_TICK        = 3'd1,
    MODE_CLEAR_PORT  = 3'd2,
    MODE_CLEAR_TIMER = 3'd3,
    MODE_CLEAR_ALL   = 3'd4
  } mode_e;

  typedef logic [CountW-1:0] count_t;
  typedef logic [TimerW-1:0] timer_t;
  typedef logic [HistW-1:0]  hist_t;

endpackage

[sv/fmpc_if.sv]
// Channel interfaces of the flow meter pulse counter: item, result and configuration.
interface fmpc_item_if;
  logic                         valid;
  logic                         ready;
  logic [fmpc_pkg::ModeW-1:0]   mode;
  logic [fmpc_pkg::LevelW-1:0]  sensor_levels;
  logic [fmpc_pkg::PortW-1:0]   port;

  modport source (output valid, mode, sensor_levels, port, input ready);
  modport sink   (input valid, mode, sensor_levels, port, output ready);
endinterface

interface fmpc_result_if;
  logic                         valid;
  logic                         ready;
  logic [fmpc_pkg::CountW-1:0]  pulse_count;
  logic [fmpc_pkg::MaskW-1:0]   valve_off_mask;
  logic [fmpc_pkg::MaskW-1:0]   pulse_seen_mask;

  modport source (output valid, pulse_count, valve_off_mask, pulse_seen_mask, input ready);
  modport sink   (input valid, pulse_count, valve_off_mask, pulse_seen_mask, output ready);
endinterface

interface fmpc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fmpc_pkg::TimerW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/flow_meter_pulse_counter.sv]
// Flow meter pulse counter: per-port debounced pulse counting with idle timeout.
//
// Usage:
//   in_i   carries one item per transaction: mode, sensor_levels and port.
//   out_o  returns exactly one result per item: the selected port's count,
//          the valve-off mask and the pulse-seen mask.
//   cfg_i  writes idle_timeout; always ready, write it only while idle.
// Result: registered, valid in the cycle after the item transaction.
// Throughput: one item per cycle unless stalled. All per-port updates finish
//   in the cycle of acceptance and land in the state and output registers.
// Stall: while a result waits and out_o.ready is low, in_i.ready is low;
//   when the receiver takes the result, a new item can be taken in the same
//   cycle, so the output register never drops or repeats a result.
// Reset: histories, counts and timers clear to zero, idle_timeout
//   returns to 1000 and no result is pending.
module flow_meter_pulse_counter #(
  parameter int unsigned PORTS = fmpc_pkg::DefaultPorts
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fmpc_item_if.sink     in_i,
  fmpc_result_if.source out_o,
  fmpc_cfg_if.sink      cfg_i
);

  fmpc_pkg::hist_t  hist_q  [PORTS];
  fmpc_pkg::hist_t  hist_d  [PORTS];
  fmpc_pkg::count_t cnt_q   [PORTS];
  fmpc_pkg::count_t cnt_d   [PORTS];
  fmpc_pkg::timer_t tmr_q   [PORTS];
  fmpc_pkg::timer_t tmr_d   [PORTS];

  fmpc_pkg::timer_t                 timeout_q;
  logic                             out_valid_q;
  fmpc_pkg::count_t                 count_q,    count_d;
  logic [fmpc_pkg::MaskW-1:0]       off_q,      off_d;
  logic [fmpc_pkg::MaskW-1:0]       seen_q,     seen_d;

  logic           in_fire;
  logic           cfg_fire;
  fmpc_pkg::mode_e mode;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign mode        = fmpc_pkg::mode_e'(in_i.mode);

  assign out_o.valid           = out_valid_q;
  assign out_o.pulse_count     = count_q;
  assign out_o.valve_off_mask  = off_q;
  assign out_o.pulse_seen_mask = seen_q;

  always_comb begin
    logic             lvl;
    logic             pulse;
    logic             sel;
    fmpc_pkg::count_t c;
    fmpc_pkg::timer_t t;
    off_d   = '0;
    seen_d  = '0;
    count_d = '0;
    for (int p = 0; p < PORTS; p++) begin
      lvl   = (p < fmpc_pkg::LevelW) ? in_i.sensor_levels[2'(p)] : 1'b0;
      sel   = (in_i.port == fmpc_pkg::PortW'(p));
      c     = cnt_q[p];
      t     = tmr_q[p];
      pulse = 1'b0;
      hist_d[p] = hist_q[p];
      unique case (mode)
        fmpc_pkg::MODE_SAMPLE: begin
          hist_d[p] = {hist_q[p][fmpc_pkg::HistW-2:0], lvl};
          pulse     = ((hist_d[p] & fmpc_pkg::HistMask) == fmpc_pkg::PulsePattern);
          if (pulse) begin
            c = c + fmpc_pkg::CountW'(1);
            t = '0;
          end
        end
        fmpc_pkg::MODE_TICK: begin
          if (c != '0 && t != fmpc_pkg::TimerMax) begin
            t = t + fmpc_pkg::TimerW'(1);
          end
        end
        fmpc_pkg::MODE_CLEAR_PORT: begin
          if (sel) begin
            c = '0;
            t = '0;
          end
        end
        fmpc_pkg::MODE_CLEAR_TIMER: begin
          if (sel) begin
            t = '0;
          end
        end
        fmpc_pkg::MODE_CLEAR_ALL: begin
          c = '0;
          t = '0;
        end
        default: begin
        end
      endcase
      if (t >= timeout_q) begin
        c = '0;
        t = '0;
        if (p < fmpc_pkg::MaskW) begin
          off_d[2'(p)] = 1'b1;
        end
      end
      if (pulse && p < fmpc_pkg::MaskW) begin
        seen_d[2'(p)] = 1'b1;
      end
      if (sel) begin
        count_d = c;
      end
      cnt_d[p] = c;
      tmr_d[p] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        hist_q[p] <= '0;
        cnt_q[p]  <= '0;
        tmr_q[p]  <= '0;
      end
      timeout_q   <= fmpc_pkg::ResetTimeout;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        timeout_q <= cfg_i.data;
      end
      if (in_fire) begin
        for (int p = 0; p < PORTS; p++) begin
          hist_q[p] <= hist_d[p];
          cnt_q[p]  <= cnt_d[p];
          tmr_q[p]  <= tmr_d[p];
        end
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q <= count_d;
      off_q   <= off_d;
      seen_q  <= seen_d;
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("no result after an item transaction");

  a_seen_only_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode != fmpc_pkg::MODE_SAMPLE |=> seen_q == '0)
    else $error("pulse reported outside sample mode");

  for (genvar g = 0; g < PORTS; g++) begin : g_chk
    a_idle_timer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] == '0 |-> tmr_q[g] == '0)
      else $error("timer running on a port with no pulses");
    if (g < fmpc_pkg::MaskW) begin : g_off
      a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
        in_fire ##1 off_q[g] |-> cnt_q[g] == '0 && tmr_q[g] == '0)
        else $error("timed-out port not cleared");
    end
  end

endmodule

[dv/flow_meter_pulse_counter_tb.sv]
// Self-checking testbench for the flow meter pulse counter with an internal behavioural predictor.
module flow_meter_pulse_counter_tb;

  localparam int unsigned NumPorts   = fmpc_pkg::DefaultPorts;
  localparam int unsigned PortIdxW   = $clog2(NumPorts);
  localparam int unsigned IdlePct    = 23;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned CalmFirst  = 600;
  localparam int unsigned CalmLast   = 850;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxPrinted = 100;

  localparam logic [fmpc_pkg::ModeW-1:0] ModeFirstUnused = 3'd5;
  localparam logic [fmpc_pkg::ModeW-1:0] ModeMidUnused   = 3'd6;
  localparam logic [fmpc_pkg::ModeW-1:0] ModeLast        = 3'd7;

  typedef struct packed {
    logic [fmpc_pkg::ModeW-1:0]  mode;
    logic [fmpc_pkg::LevelW-1:0] levels;
    logic [fmpc_pkg::PortW-1:0]  port;
  } meter_item_t;

  typedef struct packed {
    fmpc_pkg::count_t           count;
    logic [fmpc_pkg::MaskW-1:0] off_mask;
    logic [fmpc_pkg::MaskW-1:0] seen_mask;
  } meter_result_t;

  logic clk;
  logic rst_n;

  fmpc_item_if   item_ch ();
  fmpc_result_if res_ch ();
  fmpc_cfg_if    cfg_ch ();

  flow_meter_pulse_counter #(
    .PORTS(NumPorts)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_ch),
    .out_o (res_ch),
    .cfg_i (cfg_ch)
  );

  meter_item_t   pending_items[$];
  meter_result_t expected_results[$];

  fmpc_pkg::hist_t  level_hist[NumPorts];
  fmpc_pkg::count_t pulse_totals[NumPorts];
  fmpc_pkg::timer_t idle_ticks[NumPorts];
  fmpc_pkg::timer_t idle_limit;

  int     run_left[NumPorts];
  logic   level_now[NumPorts];

  int     errors        = 0;
  int     items_taken   = 0;
  int     results_seen  = 0;
  int     hold_left     = 0;
  bit     hold_done     = 1'b0;
  int     cycle_count   = 0;
  logic   calm;

  assign calm = (items_taken >= CalmFirst) && (items_taken < CalmLast);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (errors < MaxPrinted) $display("mismatch @%0d: %s", cycle_count, what);
    errors++;
  endtask

  task automatic meter_advance(input meter_item_t it);
    meter_result_t r;
    r = '0;
    case (it.mode)
      fmpc_pkg::MODE_SAMPLE: begin
        for (int p = 0; p < NumPorts; p++) begin
          level_hist[p] = {level_hist[p][fmpc_pkg::HistW-2:0],
                           (p < fmpc_pkg::LevelW) ? it.levels[p] : 1'b0};
          if ((level_hist[p] & fmpc_pkg::HistMask) == fmpc_pkg::PulsePattern) begin
            pulse_totals[p] = pulse_totals[p] + fmpc_pkg::count_t'(1);
            idle_ticks[p]   = '0;
            if (p < fmpc_pkg::MaskW) r.seen_mask[p] = 1'b1;
          end
        end
      end
      fmpc_pkg::MODE_TICK: begin
        for (int p = 0; p < NumPorts; p++) begin
          if (pulse_totals[p] != 0 && idle_ticks[p] < fmpc_pkg::TimerMax)
            idle_ticks[p] = idle_ticks[p] + fmpc_pkg::timer_t'(1);
        end
      end
      fmpc_pkg::MODE_CLEAR_PORT: begin
        if (it.port < NumPorts) begin
          pulse_totals[PortIdxW'(it.port)] = '0;
          idle_ticks[PortIdxW'(it.port)]   = '0;
        end
      end
      fmpc_pkg::MODE_CLEAR_TIMER: begin
        if (it.port < NumPorts) idle_ticks[PortIdxW'(it.port)] = '0;
      end
      fmpc_pkg::MODE_CLEAR_ALL: begin
        for (int p = 0; p < NumPorts; p++) begin
          pulse_totals[p] = '0;
          idle_ticks[p]   = '0;
        end
      end
      default: ;
    endcase
    for (int p = 0; p < NumPorts; p++) begin
      if (idle_ticks[p] >= idle_limit) begin
        pulse_totals[p] = '0;
        idle_ticks[p]   = '0;
        if (p < fmpc_pkg::MaskW) r.off_mask[p] = 1'b1;
      end
    end
    r.count = (it.port < NumPorts) ? pulse_totals[PortIdxW'(it.port)] : '0;
    expected_results.push_back(r);
  endtask

  function automatic logic [fmpc_pkg::LevelW-1:0] next_levels();
    logic [fmpc_pkg::LevelW-1:0] lv;
    lv = '0;
    for (int p = 0; p < NumPorts; p++) begin
      if (run_left[p] == 0) begin
        level_now[p] = ~level_now[p];
        run_left[p]  = ($urandom_range(9) < 6) ? 4 : $urandom_range(7, 1);
      end
      run_left[p]--;
      if (p < fmpc_pkg::LevelW) lv[p] = level_now[p];
    end
    return lv;
  endfunction

  task automatic queue_item(input logic [fmpc_pkg::ModeW-1:0] mode,
                            input logic [fmpc_pkg::LevelW-1:0] levels,
                            input logic [fmpc_pkg::PortW-1:0] port);
    meter_item_t it;
    it.mode   = mode;
    it.levels = levels;
    it.port   = port;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(input int n);
    meter_item_t it;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick      = $urandom_range(99);
      it.levels = fmpc_pkg::LevelW'($urandom);
      it.port   = ($urandom_range(4) != 0) ? fmpc_pkg::PortW'($urandom_range(NumPorts - 1))
                                           : fmpc_pkg::PortW'($urandom_range(15));
      if (pick < 55) begin
        it.mode   = fmpc_pkg::MODE_SAMPLE;
        it.levels = next_levels();
      end else if (pick < 65) begin
        it.mode = fmpc_pkg::MODE_SAMPLE;
      end else if (pick < 85) begin
        it.mode = fmpc_pkg::MODE_TICK;
      end else if (pick < 90) begin
        it.mode = fmpc_pkg::MODE_CLEAR_PORT;
      end else if (pick < 95) begin
        it.mode = fmpc_pkg::MODE_CLEAR_TIMER;
      end else if (pick < 97) begin
        it.mode = fmpc_pkg::MODE_CLEAR_ALL;
      end else begin
        it.mode = fmpc_pkg::ModeW'($urandom_range(ModeLast, ModeFirstUnused));
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
  endtask

  task automatic write_timeout(input fmpc_pkg::timer_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // drive items
  always @(posedge clk) begin : drive_items
    meter_item_t nxt;
    if (!rst_n) begin
      item_ch.valid         <= 1'b0;
      item_ch.mode          <= '0;
      item_ch.sensor_levels <= '0;
      item_ch.port          <= '0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt = pending_items.pop_front();
        item_ch.valid         <= 1'b1;
        item_ch.mode          <= nxt.mode;
        item_ch.sensor_levels <= nxt.levels;
        item_ch.port          <= nxt.port;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_items
    meter_item_t seen;
    if (rst_n && item_ch.valid && item_ch.ready) begin
      seen.mode   = item_ch.mode;
      seen.levels = item_ch.sensor_levels;
      seen.port   = item_ch.port;
      meter_advance(seen);
      items_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) idle_limit = cfg_ch.data;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done    <= 1'b1;
      hold_left    <= HoldCycles;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin : check_results
    meter_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0h off=%0h seen=%0h",
                                  res_ch.pulse_count, res_ch.valve_off_mask,
                                  res_ch.pulse_seen_mask));
      end else begin
        want = expected_results.pop_front();
        if (res_ch.pulse_count !== want.count)
          report_mismatch($sformatf("pulse_count %0h, want %0h", res_ch.pulse_count, want.count));
        if (res_ch.valve_off_mask !== want.off_mask)
          report_mismatch($sformatf("valve_off_mask %0h, want %0h",
                                    res_ch.valve_off_mask, want.off_mask));
        if (res_ch.pulse_seen_mask !== want.seen_mask)
          report_mismatch($sformatf("pulse_seen_mask %0h, want %0h",
                                    res_ch.pulse_seen_mask, want.seen_mask));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("flow_meter_pulse_counter_tb failed");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_n = 1'b0;
    idle_limit = fmpc_pkg::ResetTimeout;
    for (int p = 0; p < NumPorts; p++) begin
      level_hist[p]   = '0;
      pulse_totals[p] = '0;
      idle_ticks[p]   = '0;
      run_left[p]     = $urandom_range(5);
      level_now[p]    = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 4; i++) queue_item(fmpc_pkg::MODE_SAMPLE, 4'hF, fmpc_pkg::PortW'(i));
    for (int i = 0; i < 4; i++) queue_item(fmpc_pkg::MODE_SAMPLE, 4'h0, fmpc_pkg::PortW'(i));
    queue_item(fmpc_pkg::MODE_TICK, 4'h0, 4'd1);
    queue_item(fmpc_pkg::MODE_TICK, 4'hF, 4'd15);
    queue_item(fmpc_pkg::MODE_CLEAR_TIMER, 4'h0, 4'd1);
    queue_item(fmpc_pkg::MODE_CLEAR_TIMER, 4'h0, 4'd15);
    queue_item(fmpc_pkg::MODE_CLEAR_PORT, 4'h0, 4'd2);
    queue_item(fmpc_pkg::MODE_CLEAR_PORT, 4'h0, 4'd15);
    queue_item(ModeFirstUnused, 4'hA, 4'd3);
    queue_item(ModeMidUnused, 4'h5, 4'd9);
    queue_item(ModeLast, 4'hF, 4'd0);
    queue_item(fmpc_pkg::MODE_SAMPLE, 4'hA, 4'd4);
    queue_item(fmpc_pkg::MODE_CLEAR_ALL, 4'h0, 4'd0);
    queue_item(fmpc_pkg::MODE_TICK, 4'h0, 4'd0);
    queue_item(fmpc_pkg::MODE_SAMPLE, 4'h5, 4'd3);
    queue_item(fmpc_pkg::MODE_CLEAR_ALL, 4'hF, 4'd8);
    wait_drained();

    write_timeout('0);
    queue_random(150);
    wait_drained();

    write_timeout(16'd3);
    queue_random(400);
    wait_drained();

    write_timeout(fmpc_pkg::TimerMax);
    queue_random(200);
    wait_drained();

    write_timeout(fmpc_pkg::timer_t'($urandom_range(40, 4)));
    queue_random(400);
    wait_drained();

    write_timeout(16'd1);
    queue_random(200);
    wait_drained();

    write_timeout(fmpc_pkg::ResetTimeout);
    queue_random(150);
    wait_drained();
    repeat (4) @(posedge clk);

    if (errors == 0) begin
      $display("flow_meter_pulse_counter_tb passed");
    end else begin
      $display("flow_meter_pulse_counter_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/fmpc_pkg.sv
sv/fmpc_if.sv
sv/flow_meter_pulse_counter.sv
dv/flow_meter_pulse_counter_tb.sv
